// File: hw/rtl/goto_pose_steering_controller_core_defines.svh
// assertion macros used by the sequencer of the steering controller rtl
`ifndef GOTO_POSE_STEERING_CONTROLLER_CORE_DEFINES_SVH
`define GOTO_POSE_STEERING_CONTROLLER_CORE_DEFINES_SVH

// concurrent check on clk_i, quiet while rst_ni is low
`define GPSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// trigger in one cycle, consequence in the next
`define GPSC_ASSERT_NEXT(name, trig, cons, msg) \
  `GPSC_ASSERT(name, (trig) |=> (cons), msg)

`endif

// File: hw/rtl/gpsc_pkg.sv
// shared types, constants and tables of the steering controller
`timescale 1ns / 1ps

package gpsc_pkg;

  localparam int CFG_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = 18;
  localparam int ANG_IN_W   = 15;
  localparam int SPEED_W    = 14;
  localparam int TURN_W     = 15;
  localparam int STEP_W     = 5;
  localparam int SQRT_STEPS = 19;
  localparam int Z_W        = 35;

  localparam longint PI_Q30 = 64'sd3373259426;

  localparam logic [CFG_W-1:0] RST_POS_TOL   = 14'd205;
  localparam logic [CFG_W-1:0] RST_HEAD_TOL  = 14'd410;
  localparam logic [CFG_W-1:0] RST_TURN_MAX  = 14'd2145;
  localparam logic [CFG_W-1:0] RST_TURN_MIN  = 14'd205;
  localparam logic [CFG_W-1:0] RST_SPEED_MAX = 14'd2867;
  localparam logic [CFG_W-1:0] RST_GAIN      = 14'd2867;
  localparam logic [CFG_W-1:0] RST_ALIGN     = 14'd819;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_TOL   = 3'd0,
    REG_HEAD_TOL  = 3'd1,
    REG_TURN_MAX  = 3'd2,
    REG_TURN_MIN  = 3'd3,
    REG_SPEED_MAX = 3'd4,
    REG_GAIN      = 3'd5,
    REG_ALIGN     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic              load;
    logic              prep;
    logic              sum;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              bear;
    logic              wrap;
    logic              mul;
    logic              fin;
  } dp_cmd_t;

  typedef struct packed {
    logic wrap_done;
  } dp_status_t;

  // atan(2^-i) in q.30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 35'sd843314857;
      5'd1:    v = 35'sd497837829;
      5'd2:    v = 35'sd263043837;
      5'd3:    v = 35'sd133525159;
      5'd4:    v = 35'sd67021687;
      5'd5:    v = 35'sd33543516;
      5'd6:    v = 35'sd16775851;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194283;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048576;
      5'd11:   v = 35'sd524288;
      5'd12:   v = 35'sd262144;
      5'd13:   v = 35'sd131072;
      5'd14:   v = 35'sd65536;
      5'd15:   v = 35'sd32768;
      5'd16:   v = 35'sd16384;
      5'd17:   v = 35'sd8192;
      5'd18:   v = 35'sd4096;
      5'd19:   v = 35'sd2048;
      5'd20:   v = 35'sd1024;
      5'd21:   v = 35'sd512;
      5'd22:   v = 35'sd256;
      5'd23:   v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/gpsc_ctrl.sv
// sequencer of the steering controller
`timescale 1ns / 1ps
`include "goto_pose_steering_controller_core_defines.svh"

module gpsc_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gpsc_pkg::dp_cmd_t    cmd_o,
  input  gpsc_pkg::dp_status_t status_i
);
  import gpsc_pkg::*;

  localparam int ITER_N = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ITER_N - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_SUM, S_ITER, S_BEAR, S_WRAP, S_MUL, S_FIN
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] cnt_q;
  logic              out_valid_q;
  logic              fin_go;

  // result register free this cycle
  assign fin_go = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if ((state_q == S_FIN) && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: state_q <= S_SUM;
        S_SUM: begin
          cnt_q   <= '0;
          state_q <= S_ITER;
        end
        S_ITER: begin
          if (cnt_q == STEP_LAST) begin
            state_q <= S_BEAR;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_BEAR: state_q <= S_WRAP;
        S_WRAP: begin
          if (status_i.wrap_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep = (state_q == S_PREP);
    cmd_o.sum  = (state_q == S_SUM);
    cmd_o.iter = (state_q == S_ITER);
    cmd_o.step = cnt_q;
    cmd_o.bear = (state_q == S_BEAR);
    cmd_o.wrap = (state_q == S_WRAP);
    cmd_o.mul  = (state_q == S_MUL);
    cmd_o.fin  = (state_q == S_FIN) && fin_go;
  end

  `GPSC_ASSERT_NEXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == S_PREP, "accepted transaction did not start")
  `GPSC_ASSERT(a_step_bound, (state_q == S_ITER) |-> (cnt_q <= STEP_LAST), "iteration counter overran")
  `GPSC_ASSERT(a_valid_from_fin, $rose(out_valid_q) |-> ($past(state_q) == S_FIN), "result raised outside finish")

endmodule

// File: hw/rtl/gpsc_dp.sv
// datapath of the steering controller: cordic, square root, wrap and clamps
`timescale 1ns / 1ps

module gpsc_dp #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 12
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  gpsc_pkg::dp_cmd_t                          cmd_i,
  output gpsc_pkg::dp_status_t                       status_o,
  input  logic                                       cfg_we_i,
  input  logic [gpsc_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [gpsc_pkg::CFG_W-1:0]                 cfg_wdata_i,
  input  logic signed [gpsc_pkg::POS_W-1:0]          robot_x_i,
  input  logic signed [gpsc_pkg::POS_W-1:0]          robot_y_i,
  input  logic signed [gpsc_pkg::ANG_IN_W-1:0]       robot_heading_i,
  input  logic signed [gpsc_pkg::POS_W-1:0]          goal_x_i,
  input  logic signed [gpsc_pkg::POS_W-1:0]          goal_y_i,
  input  logic signed [gpsc_pkg::ANG_IN_W-1:0]       goal_heading_i,
  input  logic                                       ignore_heading_i,
  input  logic                                       new_goal_i,
  output logic [gpsc_pkg::SPEED_W-1:0]               forward_speed_o,
  output logic signed [gpsc_pkg::TURN_W-1:0]         turn_rate_o,
  output logic                                       arrived_o
);
  import gpsc_pkg::*;

  localparam int ANG_W  = FRAC_BITS + 10;
  localparam int D_W    = POS_W + 1;
  localparam int SQ_W   = 2 * D_W - 1;
  localparam int RAD_W  = 2 * D_W;
  localparam int ROOT_W = D_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int X_W    = D_W + 23;
  localparam int PROD_W = CFG_W + ROOT_W;

  localparam longint PiQ = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam logic signed [ANG_W-1:0] PI_A     = ANG_W'(PiQ);
  localparam logic signed [ANG_W-1:0] TWO_PI_A = ANG_W'(2 * PiQ);
  localparam logic signed [Z_W-1:0]   PI_Z     = Z_W'(PI_Q30);
  localparam logic signed [Z_W-1:0]   ROUND_Z  = Z_W'(64'sd1 <<< (29 - FRAC_BITS));

  // config registers
  logic [CFG_W-1:0] ptol_q, htol_q, tmax_q, tmin_q, smax_q, gain_q, align_q;
  logic             arr_q;

  // working registers
  logic signed [D_W-1:0]   dx_q, dy_q;
  logic signed [ANG_W-1:0] rh_q, herr_q, berr_q;
  logic                    ignore_q, in_win_q, zero_q;
  logic signed [X_W-1:0]   x_q, y_q;
  logic signed [Z_W-1:0]   z_q;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic [RAD_W-1:0]        rad_q;
  logic [REM_W-1:0]        rem_q;
  logic [ROOT_W-1:0]       root_q;
  logic [PROD_W-1:0]       prod_q;
  logic [SPEED_W-1:0]      speed_q;
  logic [TURN_W-1:0]       turn_q;
  logic                    arr_out_q;

  logic [D_W-1:0]          adx, ady;
  logic [SQ_W-1:0]         sqx, sqy;
  logic signed [X_W-1:0]   xi, yi, xs, ys;
  logic [REM_W+1:0]        rem_sh, trial;
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [ANG_W-1:0] bearing;
  logic [ANG_W-1:0]        ah, ab;
  logic [PROD_W-1:0]       spd_sh;
  logic [SPEED_W-1:0]      spd_sat, nspeed;
  logic [TURN_W-1:0]       nturn;
  logic                    narr;

  function automatic logic signed [ANG_W-1:0] wrap_step(input logic signed [ANG_W-1:0] d);
    logic signed [ANG_W-1:0] r;
    if (d > PI_A) begin
      r = d - TWO_PI_A;
    end else if (d < -PI_A) begin
      r = d + TWO_PI_A;
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic in_range(input logic signed [ANG_W-1:0] d);
    return (d <= PI_A) && (d >= -PI_A);
  endfunction

  function automatic logic [ANG_W-1:0] mag(input logic signed [ANG_W-1:0] d);
    return d[ANG_W-1] ? ANG_W'(-d) : ANG_W'(d);
  endfunction

  // clamp magnitude into [min, max], minimum wins, zero turns positive
  function automatic logic [TURN_W-1:0] clamp_turn(input logic signed [ANG_W-1:0] e,
                                                  input logic [CFG_W-1:0] hi,
                                                  input logic [CFG_W-1:0] lo);
    logic [ANG_W-1:0] m;
    logic [ANG_W-1:0] t;
    m = mag(e);
    t = (m > ANG_W'(hi)) ? ANG_W'(hi) : m;
    if (t < ANG_W'(lo)) begin
      t = ANG_W'(lo);
    end
    return e[ANG_W-1] ? TURN_W'(-t) : TURN_W'(t);
  endfunction

  assign adx = dx_q[D_W-1] ? D_W'(-dx_q) : D_W'(dx_q);
  assign ady = dy_q[D_W-1] ? D_W'(-dy_q) : D_W'(dy_q);
  assign sqx = SQ_W'(adx) * SQ_W'(adx);
  assign sqy = SQ_W'(ady) * SQ_W'(ady);
  assign xi  = X_W'(dx_q) <<< 20;
  assign yi  = X_W'(dy_q) <<< 20;
  assign xs  = x_q >>> cmd_i.step;
  assign ys  = y_q >>> cmd_i.step;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  assign z_rnd   = (z_q + ROUND_Z) >>> (30 - FRAC_BITS);
  assign bearing = zero_q ? '0 : ANG_W'(z_rnd);

  assign status_o.wrap_done = in_range(herr_q) && in_range(berr_q);

  always_comb begin
    ah      = mag(herr_q);
    ab      = mag(berr_q);
    spd_sh  = prod_q >> FRAC_BITS;
    spd_sat = (spd_sh > PROD_W'(smax_q)) ? smax_q : SPEED_W'(spd_sh);
    nspeed  = '0;
    nturn   = '0;
    narr    = arr_q;
    if (in_win_q) begin
      if ((ah < ANG_W'(htol_q)) || ignore_q) begin
        narr = 1'b1;
      end else begin
        nturn = clamp_turn(herr_q, tmax_q, tmin_q);
      end
    end else if (!arr_q) begin
      nturn = clamp_turn(berr_q, tmax_q, tmin_q);
      if (ab < ANG_W'(align_q)) begin
        nspeed = spd_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptol_q  <= RST_POS_TOL;
      htol_q  <= RST_HEAD_TOL;
      tmax_q  <= RST_TURN_MAX;
      tmin_q  <= RST_TURN_MIN;
      smax_q  <= RST_SPEED_MAX;
      gain_q  <= RST_GAIN;
      align_q <= RST_ALIGN;
      arr_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POS_TOL:   ptol_q  <= cfg_wdata_i;
          REG_HEAD_TOL:  htol_q  <= cfg_wdata_i;
          REG_TURN_MAX:  tmax_q  <= cfg_wdata_i;
          REG_TURN_MIN:  tmin_q  <= cfg_wdata_i;
          REG_SPEED_MAX: smax_q  <= cfg_wdata_i;
          REG_GAIN:      gain_q  <= cfg_wdata_i;
          REG_ALIGN:     align_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        arr_q <= arr_q & ~new_goal_i;
      end else if (cmd_i.fin) begin
        arr_q <= narr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q     <= D_W'(goal_x_i) - D_W'(robot_x_i);
      dy_q     <= D_W'(goal_y_i) - D_W'(robot_y_i);
      rh_q     <= ANG_W'(robot_heading_i);
      herr_q   <= ANG_W'(goal_heading_i) - ANG_W'(robot_heading_i);
      ignore_q <= ignore_heading_i;
    end
    if (cmd_i.prep) begin
      sqx_q    <= sqx;
      sqy_q    <= sqy;
      in_win_q <= (adx < D_W'(ptol_q)) && (ady < D_W'(ptol_q));
      zero_q   <= (dx_q == '0) && (dy_q == '0);
      // left half plane: turn by pi first
      if (dx_q[D_W-1]) begin
        x_q <= -xi;
        y_q <= -yi;
        z_q <= dy_q[D_W-1] ? -PI_Z : PI_Z;
      end else begin
        x_q <= xi;
        y_q <= yi;
        z_q <= '0;
      end
    end
    if (cmd_i.sum) begin
      rad_q  <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.iter) begin
      if (int'(cmd_i.step) < CORDIC_STEPS) begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_q30(cmd_i.step);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_q30(cmd_i.step);
        end
      end
      if (int'(cmd_i.step) < SQRT_STEPS) begin
        if (rem_sh >= trial) begin
          rem_q  <= REM_W'(rem_sh - trial);
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= REM_W'(rem_sh);
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
        rad_q <= rad_q << 2;
      end
    end
    if (cmd_i.bear) begin
      berr_q <= bearing - rh_q;
    end
    if (cmd_i.wrap) begin
      herr_q <= wrap_step(herr_q);
      berr_q <= wrap_step(berr_q);
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(gain_q) * PROD_W'(root_q);
    end
    if (cmd_i.fin) begin
      speed_q   <= nspeed;
      turn_q    <= nturn;
      arr_out_q <= narr;
    end
  end

  assign forward_speed_o = speed_q;
  assign turn_rate_o     = turn_q;
  assign arrived_o       = arr_out_q;

endmodule

// File: hw/rtl/goto_pose_steering_controller_core.sv
// top level of the go-to-pose steering controller
`timescale 1ns / 1ps

// Go-to-pose steering controller. Each input transaction carries the robot
// pose and a goal pose in q.FRAC_BITS fixed point (metres, radians); one
// result transaction follows with forward speed, turn rate and the arrived
// flag. Near the goal (both axis offsets inside position_tolerance) the block
// turns in place towards the goal heading until it is within
// heading_tolerance or the heading is ignored, then latches arrived. Away
// from the goal, and not arrived, it steers towards the bearing of the goal
// and drives at linear_gain times distance, saturated at max_linear_speed,
// only while the bearing error is inside align_window. new_goal clears
// arrived first. One transaction is worked at a time: after acceptance the
// sequencer runs a prepare step, a sum step, the shared iteration loop in
// which the cordic vectoring pass and the bit-per-cycle square root run
// side by side, a bearing step, a wrap step that is held once more for
// every 2*pi correction that a heading or bearing error needs (at most one
// at the default q.12 scaling, when a difference lies beyond pi), a
// multiply step and a finish step. A finished result sits in an output
// register, so the next transaction is taken while it waits; a further
// result is held back until that register is taken. Config writes are
// registered and are meant for idle periods.
module goto_pose_steering_controller_core #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [gpsc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gpsc_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [gpsc_pkg::POS_W-1:0]    robot_x_i,
  input  logic signed [gpsc_pkg::POS_W-1:0]    robot_y_i,
  input  logic signed [gpsc_pkg::ANG_IN_W-1:0] robot_heading_i,
  input  logic signed [gpsc_pkg::POS_W-1:0]    goal_x_i,
  input  logic signed [gpsc_pkg::POS_W-1:0]    goal_y_i,
  input  logic signed [gpsc_pkg::ANG_IN_W-1:0] goal_heading_i,
  input  logic                                 ignore_heading_i,
  input  logic                                 new_goal_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [gpsc_pkg::SPEED_W-1:0]         forward_speed_o,
  output logic signed [gpsc_pkg::TURN_W-1:0]   turn_rate_o,
  output logic                                 arrived_o
);
  import gpsc_pkg::*;

  // commands from the sequencer, status back from the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  gpsc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // datapath holds config, arrived state and the result register
  gpsc_dp #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .robot_x_i       (robot_x_i),
    .robot_y_i       (robot_y_i),
    .robot_heading_i (robot_heading_i),
    .goal_x_i        (goal_x_i),
    .goal_y_i        (goal_y_i),
    .goal_heading_i  (goal_heading_i),
    .ignore_heading_i(ignore_heading_i),
    .new_goal_i      (new_goal_i),
    .forward_speed_o (forward_speed_o),
    .turn_rate_o     (turn_rate_o),
    .arrived_o       (arrived_o)
  );

endmodule

// File: test/goto_pose_steering_controller_core_test.sv
// self-checking testbench of the go-to-pose steering controller core
`timescale 1ns / 1ps

module goto_pose_steering_controller_core_test;
  import gpsc_pkg::*;

  localparam longint PI_Q12 = 12868;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd7;
  localparam logic [13:0] REG_MAX = 14'h3fff;

  typedef struct {
    logic signed [POS_W-1:0]    robot_x;
    logic signed [POS_W-1:0]    robot_y;
    logic signed [ANG_IN_W-1:0] robot_heading;
    logic signed [POS_W-1:0]    goal_x;
    logic signed [POS_W-1:0]    goal_y;
    logic signed [ANG_IN_W-1:0] goal_heading;
    logic                       ignore_heading;
    logic                       new_goal;
  } pose_t;

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic [TURN_W-1:0]  turn;
    logic               arrived;
  } steer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [POS_W-1:0] robot_x_i, robot_y_i, goal_x_i, goal_y_i;
  logic signed [ANG_IN_W-1:0] robot_heading_i, goal_heading_i;
  logic ignore_heading_i, new_goal_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [SPEED_W-1:0] forward_speed_o;
  logic signed [TURN_W-1:0] turn_rate_o;
  logic arrived_o;

  // model state: register copies and the arrived latch
  logic [CFG_W-1:0] cfg_shadow [7];
  logic arrived_shadow;
  steer_result_t expected_steer [$];

  int mismatch_count = 0;
  int sent_count = 0;
  int result_count = 0;
  int cfg_count = 0;
  longint cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;

  goto_pose_steering_controller_core uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .robot_x_i, .robot_y_i, .robot_heading_i,
    .goal_x_i, .goal_y_i, .goal_heading_i, .ignore_heading_i, .new_goal_i,
    .out_valid_o, .out_stall_i, .forward_speed_o, .turn_rate_o, .arrived_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("goto_pose_steering_controller_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // fold an angle difference into [-pi, pi]
  function automatic longint wrap_pi(longint d);
    while (d > PI_Q12) d -= 2 * PI_Q12;
    while (d < -PI_Q12) d += 2 * PI_Q12;
    return d;
  endfunction

  // clamp to max magnitude, then lift to min magnitude; min wins
  function automatic longint clamp_turn_rate(longint e);
    longint s;
    longint t;
    s = (e < 0) ? -1 : 1;
    t = e;
    if ((t < 0 ? -t : t) > longint'(cfg_shadow[REG_TURN_MAX]))
      t = s * longint'(cfg_shadow[REG_TURN_MAX]);
    if ((t < 0 ? -t : t) < longint'(cfg_shadow[REG_TURN_MIN]))
      t = s * longint'(cfg_shadow[REG_TURN_MIN]);
    return t;
  endfunction

  // cordic vectoring atan2 with a q.30 accumulator, rounded to q.12
  function automatic longint goal_bearing(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * (longint'(1) << 20);
    y = y * (longint'(1) << 20);
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(atan_q30(i[STEP_W-1:0]));
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(atan_q30(i[STEP_W-1:0]));
      end
    end
    return (z + (longint'(1) << 17)) >>> 18;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // one step of the steering law; updates the arrived latch
  function automatic steer_result_t predict_steering(pose_t p);
    steer_result_t res;
    longint dx, dy, herr, berr, turn, ptol;
    longint unsigned goal_range, spd;
    dx = longint'(p.goal_x) - longint'(p.robot_x);
    dy = longint'(p.goal_y) - longint'(p.robot_y);
    herr = wrap_pi(longint'(p.goal_heading) - longint'(p.robot_heading));
    ptol = longint'(cfg_shadow[REG_POS_TOL]);
    spd = 0;
    turn = 0;
    if (p.new_goal) arrived_shadow = 1'b0;
    if ((dx < 0 ? -dx : dx) < ptol && (dy < 0 ? -dy : dy) < ptol) begin
      if ((herr < 0 ? -herr : herr) < longint'(cfg_shadow[REG_HEAD_TOL]) || p.ignore_heading)
        arrived_shadow = 1'b1;
      else
        turn = clamp_turn_rate(herr);
    end else if (!arrived_shadow) begin
      berr = wrap_pi(goal_bearing(dy, dx) - longint'(p.robot_heading));
      turn = clamp_turn_rate(berr);
      if ((berr < 0 ? -berr : berr) < longint'(cfg_shadow[REG_ALIGN])) begin
        goal_range = floor_sqrt(longint'(dx * dx + dy * dy));
        spd = (longint'(cfg_shadow[REG_GAIN]) * goal_range) >> 12;
        if (spd > cfg_shadow[REG_SPEED_MAX]) spd = cfg_shadow[REG_SPEED_MAX];
      end
    end
    res.speed = spd[SPEED_W-1:0];
    res.turn = turn[TURN_W-1:0];
    res.arrived = arrived_shadow;
    return res;
  endfunction

  // ------------------------------------------------------------ result side

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // receiver stall, with an optional long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // compare every accepted result transaction with the oldest expectation
  always @(posedge clk_i) begin
    steer_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (expected_steer.size() == 0) begin
        report_mismatch("unexpected result transaction", result_count, 0);
      end else begin
        exp_r = expected_steer.pop_front();
        if (forward_speed_o !== exp_r.speed)
          report_mismatch("forward_speed", forward_speed_o, exp_r.speed);
        if (turn_rate_o !== exp_r.turn)
          report_mismatch("turn_rate", $signed(turn_rate_o), $signed(exp_r.turn));
        if (arrived_o !== exp_r.arrived)
          report_mismatch("arrived", arrived_o, exp_r.arrived);
      end
    end
  end

  // ------------------------------------------------------------ stimulus side

  // offer one pose transaction; valid stays high afterwards for back-to-back
  task automatic send_pose(pose_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    robot_x_i <= p.robot_x;
    robot_y_i <= p.robot_y;
    robot_heading_i <= p.robot_heading;
    goal_x_i <= p.goal_x;
    goal_y_i <= p.goal_y;
    goal_heading_i <= p.goal_heading;
    ignore_heading_i <= p.ignore_heading;
    new_goal_i <= p.new_goal;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_steer.insert(expected_steer.size(), predict_steering(p));
    sent_count++;
  endtask

  // drop valid and let every pending result come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_steer.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < 7) cfg_shadow[idx] = val;
    cfg_count++;
  endtask

  task automatic write_all_regs(logic [CFG_W-1:0] v [7]);
    write_reg(REG_POS_TOL, v[0]);
    write_reg(REG_HEAD_TOL, v[1]);
    write_reg(REG_TURN_MAX, v[2]);
    write_reg(REG_TURN_MIN, v[3]);
    write_reg(REG_SPEED_MAX, v[4]);
    write_reg(REG_GAIN, v[5]);
    write_reg(REG_ALIGN, v[6]);
  endtask

  function automatic logic signed [ANG_IN_W-1:0] rand_heading();
    // mostly inside [-pi, pi], sometimes any 15-bit value
    if ($urandom_range(9) == 0) return ANG_IN_W'($urandom);
    return ANG_IN_W'($urandom_range(2 * PI_Q12) - PI_Q12);
  endfunction

  // goal near the robot, far from it, or plain random bits
  function automatic pose_t rand_pose();
    pose_t p;
    int span;
    int kind;
    kind = $urandom_range(9);
    p.robot_x = POS_W'($urandom);
    p.robot_y = POS_W'($urandom);
    p.robot_heading = rand_heading();
    p.goal_heading = rand_heading();
    p.ignore_heading = $urandom_range(3) == 0;
    p.new_goal = $urandom_range(4) == 0;
    span = 2 * int'(cfg_shadow[REG_POS_TOL]) + 2;
    if (kind < 4) begin
      p.goal_x = p.robot_x + POS_W'($urandom_range(2 * span) - span);
      p.goal_y = p.robot_y + POS_W'($urandom_range(2 * span) - span);
    end else if (kind < 8) begin
      p.goal_x = p.robot_x + POS_W'($urandom_range(40000) - 20000);
      p.goal_y = p.robot_y + POS_W'($urandom_range(40000) - 20000);
    end else begin
      p.goal_x = POS_W'($urandom);
      p.goal_y = POS_W'($urandom);
    end
    return p;
  endfunction

  function automatic pose_t make_pose(int rx, int ry, int rh, int gx, int gy, int gh,
                                      bit ign, bit ng);
    pose_t p;
    p.robot_x = POS_W'(rx);
    p.robot_y = POS_W'(ry);
    p.robot_heading = ANG_IN_W'(rh);
    p.goal_x = POS_W'(gx);
    p.goal_y = POS_W'(gy);
    p.goal_heading = ANG_IN_W'(gh);
    p.ignore_heading = ign;
    p.new_goal = ng;
    return p;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_pose(rand_pose());
  endtask

  // ------------------------------------------------------------------ tests

  // field extremes, arrival, turning in place, bearing path, wraps
  task automatic test_directed();
    // arrived after reset: far goal gives nothing
    send_pose(make_pose(0, 0, 0, 40000, 0, 0, 0, 0));
    // new goal far away, aligned and at opposite heading
    send_pose(make_pose(0, 0, 0, 40000, 0, 0, 0, 1));
    send_pose(make_pose(0, 0, 12868, 40000, 0, 0, 0, 0));
    send_pose(make_pose(0, 0, -12868, -40000, 1, 0, 0, 0));
    send_pose(make_pose(0, 0, 12868, -40000, -1, 0, 0, 0));
    // inside window with a heading error, then an error within tolerance
    send_pose(make_pose(100, 100, 0, 150, 50, 6000, 0, 0));
    send_pose(make_pose(100, 100, 0, 150, 50, -100, 0, 0));
    // heading wraps across pi, and extremes of the heading field
    send_pose(make_pose(0, 0, 12868, 10, 10, -12868, 0, 0));
    send_pose(make_pose(0, 0, -16384, 10, 10, 16383, 0, 0));
    // heading ignored: arrives
    send_pose(make_pose(0, 0, 0, 10, 10, 9000, 1, 0));
    // heading reached: arrives and stays arrived
    send_pose(make_pose(0, 0, 500, 10, 10, 600, 0, 1));
    send_pose(make_pose(0, 0, 0, 100000, 0, 0, 0, 0));
    // position extremes, differences beyond the field width
    send_pose(make_pose(-131072, -131072, 0, 131071, 131071, 0, 0, 1));
    send_pose(make_pose(131071, 131071, -12868, -131072, -131072, 0, 0, 0));
    send_pose(make_pose(131071, -131072, 3000, -131072, 131071, 0, 0, 0));
    send_pose(make_pose(0, 0, 0, 0, 200000, 0, 0, 0));
    send_pose(make_pose(0, 0, 6434, 0, 1000, 0, 0, 0));
    wait_idle();
    // zero tolerance: zero offset takes the bearing path with bearing zero
    write_reg(REG_POS_TOL, 14'd0);
    send_pose(make_pose(5, 5, 0, 5, 5, 0, 0, 1));
    send_pose(make_pose(5, 5, -3000, 5, 5, 0, 1, 0));
    wait_idle();
    // a spare register index changes nothing
    write_reg(SPARE_REG_IDX, 14'h2aaa);
    send_pose(make_pose(0, 0, 0, 3000, 3000, 0, 0, 1));
    wait_idle();
  endtask

  // several register settings, extremes among them, random poses in each
  task automatic test_config_sweep(int per_phase);
    logic [CFG_W-1:0] v [7];
    v = '{14'd205, 14'd410, 14'd2145, 14'd205, 14'd2867, 14'd2867, 14'd819};
    write_all_regs(v);
    send_random(per_phase);
    wait_idle();
    v = '{14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0};
    write_all_regs(v);
    send_random(per_phase);
    wait_idle();
    v = '{REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX};
    write_all_regs(v);
    send_random(per_phase);
    wait_idle();
    // minimum above maximum, wide align window
    v = '{14'd400, 14'd100, 14'd300, 14'd900, 14'd9000, 14'd12000, 14'd16000};
    write_all_regs(v);
    send_random(per_phase);
    wait_idle();
    for (int k = 0; k < 7; k++) v[k] = CFG_W'($urandom);
    write_all_regs(v);
    send_random(per_phase);
    wait_idle();
    v = '{14'd205, 14'd410, 14'd2145, 14'd205, 14'd2867, 14'd2867, 14'd819};
    write_all_regs(v);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_request = 1;
    send_random(20);
    wait_idle();
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    send_random(15);
    wait_idle();
    send_random(15);
    wait_idle();
  endtask

  initial begin
    cfg_shadow = '{RST_POS_TOL, RST_HEAD_TOL, RST_TURN_MAX, RST_TURN_MIN,
                   RST_SPEED_MAX, RST_GAIN, RST_ALIGN};
    arrived_shadow = 1'b1;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_POS_TOL;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    robot_x_i <= '0;
    robot_y_i <= '0;
    robot_heading_i <= '0;
    goal_x_i <= '0;
    goal_y_i <= '0;
    goal_heading_i <= '0;
    ignore_heading_i <= 1'b0;
    new_goal_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // sender rarely idles, receiver mostly stalls
    sender_idle_pct = 6;
    recv_stall_pct = 70;
    test_directed();
    test_config_sweep(35);
    // other way round
    sender_idle_pct = 70;
    recv_stall_pct = 6;
    test_config_sweep(35);
    test_drain_pause();
    // no idling at all
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_config_sweep(20);
    send_random(30);
    wait_idle();

    $display("covered %0d pose transactions, %0d results, %0d register writes",
             sent_count, result_count, cfg_count);
    $display("settings: reset, all zero, all max, min above max, random; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_steer.size() == 0) begin
      $display("goto_pose_steering_controller_core: match");
    end else begin
      $display("goto_pose_steering_controller_core: mismatch");
    end
    $finish;
  end

endmodule
